// ----- hw/rtl/text_console_writer_defines.svh -----
// assertion macros shared by the text console writer rtl
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// shared constants and types of the text console writer
package tcw_pkg;

	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_ROWS     = 25;
	localparam int DEF_TAB_STOP = 8;

	localparam int CELL_W = 16;

	localparam logic [7:0] RESET_BLANK_ATTR = 8'h0F;
	localparam logic [7:0] SPACE_CHAR       = 8'h20;
	localparam logic [7:0] CH_BS            = 8'h08;
	localparam logic [7:0] CH_TAB           = 8'h09;
	localparam logic [7:0] CH_LF            = 8'h0A;
	localparam logic [7:0] CH_CR            = 8'h0D;
	localparam logic [7:0] CH_DEL           = 8'h7F;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// what a put does beyond moving the cursor
	typedef struct packed {
		logic store;
		logic scroll;
	} put_evt_t;

endpackage

// ----- hw/rtl/tcw_screen_ram.sv -----
// screen cell memory: one write port, one read port with registered data
module tcw_screen_ram #(
	parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/tcw_cursor.sv -----
// cursor column, tab phase and row base, with the put control-code handling
module tcw_cursor #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             put,
	input  logic                             clr,
	input  logic [7:0]                       char_code,
	output tcw_pkg::put_evt_t                evt,
	output logic [$clog2(COLUMNS*ROWS)-1:0] loc
);
	import tcw_pkg::*;

	localparam int LOC_W = $clog2(COLUMNS * ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int NW    = $clog2(COLUMNS + TAB_STOP);
	localparam int PW    = $clog2(TAB_STOP);
	localparam logic [LOC_W-1:0] LAST_BASE = LOC_W'((ROWS - 1) * COLUMNS);

	logic [COL_W-1:0] col_q;
	logic [PW-1:0]    phase_q;
	logic [LOC_W-1:0] base_q;

	logic [NW-1:0] col_n;
	logic [PW-1:0] phase_n;
	logic          adv;
	logic          store;
	logic          scroll;

	// phase_q tracks col_q modulo the tab stop
	always_comb begin
		col_n   = NW'(col_q);
		phase_n = phase_q;
		adv     = 1'b0;
		store   = 1'b0;
		if (char_code == CH_BS && col_q != '0) begin
			col_n   = NW'(col_q) - NW'(1);
			phase_n = (phase_q == '0) ? PW'(TAB_STOP - 1) : phase_q - PW'(1);
		end else if (char_code == CH_TAB) begin
			col_n   = NW'(col_q) + NW'(TAB_STOP) - NW'(phase_q);
			phase_n = '0;
		end else if (char_code == CH_CR) begin
			col_n   = '0;
			phase_n = '0;
		end else if (char_code == CH_LF) begin
			col_n   = '0;
			phase_n = '0;
			adv     = 1'b1;
		end else if (char_code inside {[SPACE_CHAR:CH_DEL]}) begin
			store   = 1'b1;
			col_n   = NW'(col_q) + NW'(1);
			phase_n = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
		end
		// line wrap
		if (col_n >= NW'(COLUMNS)) begin
			col_n   = '0;
			phase_n = '0;
			adv     = 1'b1;
		end
		scroll = adv && (base_q == LAST_BASE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= '0;
			base_q  <= '0;
		end else if (clr) begin
			col_q   <= '0;
			phase_q <= '0;
			base_q  <= '0;
		end else if (put) begin
			col_q   <= col_n[COL_W-1:0];
			phase_q <= phase_n;
			if (adv && !scroll) begin
				base_q <= base_q + LOC_W'(COLUMNS);
			end
		end
	end

	assign evt.store  = store;
	assign evt.scroll = scroll;
	assign loc        = base_q + LOC_W'(col_q);

endmodule

// ----- hw/rtl/tcw_seq.sv -----
// sequencer: drives the screen memory for puts, reads, clear and scroll sweeps
module tcw_seq #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        char_code,
	input  logic [3:0]                        back_color,
	input  logic [3:0]                        fore_color,
	input  logic [$clog2(COLUMNS*ROWS)-1:0]  cell_index,
	input  logic [7:0]                        blank_attr,
	input  tcw_pkg::put_evt_t                 evt,
	input  logic [$clog2(COLUMNS*ROWS)-1:0]  put_addr,
	input  logic [tcw_pkg::CELL_W-1:0]        rdata,
	output logic                              ram_we,
	output logic [$clog2(COLUMNS*ROWS)-1:0]  ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]        ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(COLUMNS*ROWS)-1:0]  ram_raddr,
	output logic                              idle,
	output logic                              done,
	output logic [tcw_pkg::CELL_W-1:0]        res_data
);
	import tcw_pkg::*;

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int COPY_END = CELLS - COLUMNS;

	typedef enum logic [3:0] {
		ST_FILL   = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_FINISH = 4'b1000
	} seq_state_t;

	seq_state_t     state_q, state_n;
	logic [AW-1:0]  cnt_q, cnt_n;
	logic           pend_q, pend_n;
	logic           hit_q, hit_n;
	logic [7:0]     attr_q, attr_n;
	logic [AW:0]    ahead;
	logic           idx_ok;
	logic [CELL_W-1:0] blank;

	assign blank  = {attr_q, SPACE_CHAR};
	assign ahead  = {1'b0, cnt_q} + (AW+1)'(COLUMNS + 1);
	assign idx_ok = {1'b0, cell_index} < (AW+1)'(CELLS);

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		pend_n    = pend_q;
		hit_n     = hit_q;
		attr_n    = attr_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank;
		ram_re    = 1'b0;
		ram_raddr = cell_index;
		idle      = 1'b0;
		done      = 1'b0;
		case (state_q)
			ST_FILL: begin
				ram_we = 1'b1;
				cnt_n  = cnt_q + AW'(1);
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_n   = '0;
					pend_n  = 1'b0;
					state_n = pend_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				idle = 1'b1;
				if (acc) begin
					attr_n  = blank_attr;
					hit_n   = 1'b0;
					cnt_n   = '0;
					state_n = ST_FINISH;
					case (kind)
						KIND_PUT: begin
							ram_we    = evt.store;
							ram_waddr = put_addr;
							ram_wdata = {back_color, fore_color, char_code};
							if (evt.scroll) begin
								// prime the copy with the first cell of row one
								ram_re    = 1'b1;
								ram_raddr = AW'(COLUMNS);
								state_n   = ST_SCROLL;
							end
						end
						KIND_CLEAR: begin
							pend_n  = 1'b1;
							state_n = ST_FILL;
						end
						KIND_READ: begin
							ram_re = idx_ok;
							hit_n  = idx_ok;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				// read one row ahead, write the cell fetched last cycle
				ram_we    = 1'b1;
				ram_wdata = (cnt_q < AW'(COPY_END)) ? rdata : blank;
				ram_re    = ahead < (AW+1)'(CELLS);
				ram_raddr = ahead[AW-1:0];
				cnt_n     = cnt_q + AW'(1);
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_n   = '0;
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				done    = 1'b1;
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign res_data = hit_q ? rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			hit_q   <= 1'b0;
			attr_q  <= RESET_BLANK_ATTR;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
			hit_q   <= hit_n;
			attr_q  <= attr_n;
		end
	end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// text console writer top level: handshakes, config register, result register
//
// Keeps a COLUMNS x ROWS screen of 16-bit cells (attribute byte above character
// byte) in one synchronous memory, plus a cursor. Reads, unknown items and puts
// that do not scroll are accepted, and the next cycle registers their result; a
// read gets its cell from the memory's registered read port in that cycle. A
// clear item writes every cell through the single write port, one cell a cycle.
// A put that moves past the last row scrolls: a copy sweep reads one row ahead
// and writes one cell a cycle, then blanks the last row. After reset the memory
// is cleared to blank cells in a pass during which no item is accepted;
// blank_attr writes are taken at any time. A finished result waits in the
// output register while the next item is accepted once that register is free
// or being emptied.
`include "text_console_writer_defines.svh"

module text_console_writer #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [7:0]                        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        char_code,
	input  logic [3:0]                        back_color,
	input  logic [3:0]                        fore_color,
	input  logic [$clog2(COLUMNS*ROWS)-1:0]  cell_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [$clog2(COLUMNS*ROWS)-1:0]  cursor_location,
	output logic [tcw_pkg::CELL_W-1:0]        cell_data
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int LOC_W = $clog2(CELLS);

	logic [7:0]        blank_attr_q;
	logic              out_valid_q;
	logic [LOC_W-1:0]  cursor_location_q;
	logic [CELL_W-1:0] cell_data_q;

	logic              in_acc;
	logic              seq_idle;
	logic              seq_done;
	logic [CELL_W-1:0] res_data;
	put_evt_t          evt;
	logic [LOC_W-1:0]  cur_loc;

	logic              ram_we;
	logic [LOC_W-1:0]  ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [LOC_W-1:0]  ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic              loc_ok;

	assign in_stall = !seq_idle || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= RESET_BLANK_ATTR;
		end else if (cfg_wr_en) begin
			blank_attr_q <= cfg_wr_data;
		end
	end

	tcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.put       (in_acc && kind == KIND_PUT),
		.clr       (in_acc && kind == KIND_CLEAR),
		.char_code (char_code),
		.evt       (evt),
		.loc       (cur_loc)
	);

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (in_acc),
		.kind       (kind),
		.char_code  (char_code),
		.back_color (back_color),
		.fore_color (fore_color),
		.cell_index (cell_index),
		.blank_attr (blank_attr_q),
		.evt        (evt),
		.put_addr   (cur_loc),
		.rdata      (ram_rdata),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.idle       (seq_idle),
		.done       (seq_done),
		.res_data   (res_data)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (LOC_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register between the core and the output channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			cursor_location_q <= cur_loc;
			cell_data_q       <= res_data;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_location = cursor_location_q;
	assign cell_data       = cell_data_q;

	assign loc_ok = {1'b0, cursor_location_q} < (LOC_W+1)'(CELLS);

	`TCW_ASSERT_NOW(a_result_slot_free, clk, arst_n, seq_done, !out_valid_q, "result overwrote a pending transaction")
	`TCW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall, "second transaction taken while one is in flight")
	`TCW_ASSERT_NOW(a_cursor_in_range, clk, arst_n, out_valid_q, loc_ok, "cursor location beyond the screen")

endmodule
